// ===== hw/rtl/lav_pkg.sv =====
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants and codes for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Width of every matrix entry and vector component on the ports.
  localparam int unsigned DW = 32;

  // Normalization puts the largest magnitude's leading one at this bit.
  localparam int unsigned NORM_MSB = 30;
  localparam int unsigned MAG_W    = NORM_MSB + 1;

  typedef enum logic {
    OP_FORWARD = 1'b0,
    OP_TARGET  = 1'b1
  } op_e;

  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;
  localparam logic [1:0] ROW_LAST  = 2'd3;

endpackage

// ===== hw/rtl/lav_norm.sv =====
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: magnitude scaling, sum of squares, a square
// root of one result bit per stage and three restoring dividers of one
// quotient bit per stage. A side word travels along with each vector.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int unsigned W         = 64,
  parameter int unsigned P         = 1,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [2:0][W-1:0]             v_i,
  input  logic [P-1:0]                  side_i,
  output logic                          valid_o,
  output logic [2:0][FRAC_BITS+1:0]     n_o,
  output logic                          zero_o,
  output logic [P-1:0]                  side_o
);

  localparam int unsigned MW  = lav_pkg::MAG_W;
  localparam int unsigned LW  = $clog2(W);
  localparam int unsigned NCH = (W + 7) / 8;
  localparam int unsigned CHW = NCH * 8;
  localparam int unsigned QSW = 2 * MW;
  localparam int unsigned SW  = QSW + 2;
  localparam int unsigned RW  = SW / 2;
  localparam int unsigned QW  = FRAC_BITS + 1;
  localparam int unsigned NW  = FRAC_BITS + 2;
  localparam int unsigned DRW = RW + 1;

  typedef struct packed {
    logic [2:0][W-1:0] m;
    logic [2:0]        sgn;
    logic [P-1:0]      side;
  } wide_t;

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    logic [2:0]         sgn;
    logic               zero;
    logic [P-1:0]       side;
  } carry_t;

  // Magnitudes and their maximum.
  wide_t          a_d, a_q;
  logic [W-1:0]   amx_d, amx_q;
  logic           a_v_q;

  always_comb begin
    a_d.side = side_i;
    amx_d    = '0;
    for (int i = 0; i < 3; i++) begin
      a_d.sgn[i] = v_i[i][W-1];
      a_d.m[i]   = v_i[i][W-1] ? (~v_i[i] + W'(1)) : v_i[i];
      if (a_d.m[i] > amx_d) begin
        amx_d = a_d.m[i];
      end
    end
  end

  // Leading one of the maximum, first per byte.
  wide_t                b_q;
  logic [NCH-1:0]       bnz_d, bnz_q;
  logic [NCH-1:0][2:0]  bpos_d, bpos_q;
  logic                 bz_q;
  logic                 b_v_q;
  logic [CHW-1:0]       bpad;

  always_comb begin
    bpad = CHW'(amx_q);
    for (int c = 0; c < NCH; c++) begin
      bnz_d[c]  = |bpad[c*8 +: 8];
      bpos_d[c] = '0;
      for (int k = 0; k < 8; k++) begin
        if (bpad[c*8 + k]) begin
          bpos_d[c] = 3'(k);
        end
      end
    end
  end

  // Then across bytes.
  wide_t           c_q;
  logic [LW-1:0]   clead_d, clead_q;
  logic            cz_q;
  logic            c_v_q;

  always_comb begin
    clead_d = '0;
    for (int c = 0; c < NCH; c++) begin
      if (bnz_q[c]) begin
        clead_d = LW'(c * 8 + int'(bpos_q[c]));
      end
    end
  end

  // Scale so that the largest magnitude has its leading one at NORM_MSB.
  carry_t          d_d, d_q;
  logic            d_v_q;
  logic [W-1:0]    dsh;

  always_comb begin
    d_d.sgn  = c_q.sgn;
    d_d.zero = cz_q;
    d_d.side = c_q.side;
    dsh      = '0;
    for (int i = 0; i < 3; i++) begin
      if (clead_q > LW'(lav_pkg::NORM_MSB)) begin
        dsh = c_q.m[i] >> (clead_q - LW'(lav_pkg::NORM_MSB));
      end else begin
        dsh = c_q.m[i] << (LW'(lav_pkg::NORM_MSB) - clead_q);
      end
      d_d.m[i] = dsh[MW-1:0];
    end
  end

  // Squares.
  carry_t               e_q;
  logic [2:0][QSW-1:0]  esq_d, esq_q;
  logic                 e_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      esq_d[i] = QSW'(d_q.m[i]) * QSW'(d_q.m[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_d;
      amx_q   <= amx_d;
      b_q     <= a_q;
      bnz_q   <= bnz_d;
      bpos_q  <= bpos_d;
      bz_q    <= (amx_q == '0);
      c_q     <= b_q;
      clead_q <= clead_d;
      cz_q    <= bz_q;
      d_q     <= d_d;
      e_q     <= d_q;
      esq_q   <= esq_d;
    end
  end

  // Square root, one result bit per stage. Stage 0 holds the sum of squares.
  logic [SW-1:0]  sx_q [RW+1];
  logic [SW-1:0]  sr_q [RW+1];
  carry_t         sc_q [RW+1];
  logic [RW:0]    sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q[0] <= SW'(esq_q[0]) + SW'(esq_q[1]) + SW'(esq_q[2]);
      sr_q[0] <= '0;
      sc_q[0] <= e_q;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam logic [SW-1:0] Bit = SW'(1) << (SW - 2 - 2 * k);
    logic [SW-1:0] trial, x_d, r_d;

    always_comb begin
      trial = sr_q[k] + Bit;
      if (sx_q[k] >= trial) begin
        x_d = sx_q[k] - trial;
        r_d = (sr_q[k] >> 1) + Bit;
      end else begin
        x_d = sx_q[k];
        r_d = sr_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[k+1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sx_q[k+1] <= x_d;
        sr_q[k+1] <= r_d;
        sc_q[k+1] <= sc_q[k];
      end
    end
  end

  // Division (m << FRAC_BITS) / L. The quotient never exceeds 2^FRAC_BITS, so
  // the remainder starts from the bits of the numerator above that.
  logic [2:0][DRW-1:0]  dr_q [QW+1];
  logic [2:0][QW-1:0]   dq_q [QW+1];
  logic [RW-1:0]        dl_q [QW+1];
  carry_t               dc_q [QW+1];
  logic [QW:0]          dv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sv_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= DRW'(sc_q[RW].m[i] >> 1);
      end
      dq_q[0] <= '0;
      dl_q[0] <= sr_q[RW][RW-1:0];
      dc_q[0] <= sc_q[RW];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [2:0][DRW-1:0] r_d;
    logic [2:0][QW-1:0]  q_d;
    logic [DRW-1:0]      t;
    logic                nb;

    always_comb begin
      t  = '0;
      nb = 1'b0;
      for (int i = 0; i < 3; i++) begin
        nb = (j == 0) ? dc_q[j].m[i][0] : 1'b0;
        t  = {dr_q[j][i][DRW-2:0], nb};
        if (t >= {1'b0, dl_q[j]}) begin
          r_d[i] = t - {1'b0, dl_q[j]};
          q_d[i] = {dq_q[j][i][QW-2:0], 1'b1};
        end else begin
          r_d[i] = t;
          q_d[i] = {dq_q[j][i][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[j+1] <= r_d;
        dq_q[j+1] <= q_d;
        dl_q[j+1] <= dl_q[j];
        dc_q[j+1] <= dc_q[j];
      end
    end
  end

  // Sign and zero-length handling.
  logic [2:0][NW-1:0] n_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dc_q[QW].zero) begin
        n_d[i] = '0;
      end else if (dc_q[QW].sgn[i]) begin
        n_d[i] = -NW'(dq_q[QW][i]);
      end else begin
        n_d[i] = NW'(dq_q[QW][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= dv_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o    <= n_d;
      zero_o <= dc_q[QW].zero;
      side_o <= dc_q[QW].side;
    end
  end

endmodule

// ===== hw/rtl/look_at_view_matrix.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Builds a 4x4 view matrix in signed fixed point from a camera position, an
// aim vector and an up vector, and sends it out as four row words.
// ----------------------------------------------------------------------------
// A word is accepted on every cycle in which the pipeline can move; the
// matrix leaves as four row words, top row first, so the sustained input
// rate is set by the single output channel. The work runs through two
// normalizers of 41 + FRAC_BITS stages each plus seven stages of forward,
// cross product and translation math. Translations are saturated to 32
// bits, and a zero-length forward vector in target mode or a zero-length
// right vector gives zero entries for that vector and raises degenerate on
// all four rows.
module look_at_view_matrix #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] cam_x_i,
  input  logic [31:0] cam_y_i,
  input  logic [31:0] cam_z_i,
  input  logic [31:0] aim_x_i,
  input  logic [31:0] aim_y_i,
  input  logic [31:0] aim_z_i,
  input  logic [31:0] up_x_i,
  input  logic [31:0] up_y_i,
  input  logic [31:0] up_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  row_index_o,
  output logic [31:0] col0_o,
  output logic [31:0] col1_o,
  output logic [31:0] col2_o,
  output logic [31:0] col3_o,
  output logic        degenerate_o,
  output logic        last_row_o
);

  localparam int unsigned DW   = lav_pkg::DW;
  localparam int unsigned NW   = FRAC_BITS + 2;
  localparam int unsigned PW   = 2 * DW + 1;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned CRW  = 2 * DW;
  localparam logic signed [SUMW-1:0] SatHi = SUMW'(2147483647);
  localparam logic signed [SUMW-1:0] SatLo = -SatHi - SUMW'(1);
  localparam logic [DW-1:0] One = DW'(1) << FRAC_BITS;

  typedef struct packed {
    logic               op;
    logic [2:0][DW-1:0] cam;
    logic [2:0][DW-1:0] aim;
    logic [2:0][DW-1:0] up;
  } s1_t;

  typedef struct packed {
    logic               deg;
    logic [2:0][DW-1:0] cam;
    logic [2:0][DW-1:0] up;
    logic [2:0][DW-1:0] nf;
  } s2_t;

  typedef struct packed {
    logic [2:0][2:0][DW-1:0] rows;
    logic [2:0][DW-1:0]      t;
    logic                    deg;
  } tail_t;

  logic en;
  logic take;
  logic out_acc;

  // Input register.
  s1_t p0_q;
  logic p0_v_q;
  logic [2:0][DW:0] diff;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = {p0_q.aim[i][DW-1], p0_q.aim[i]} - {p0_q.cam[i][DW-1], p0_q.cam[i]};
    end
  end

  // Forward vector in look-at mode.
  logic               n1_v;
  logic [2:0][NW-1:0] n1_f;
  logic               n1_z;
  s1_t                n1_s;

  lav_norm #(
    .W         (DW + 1),
    .P         ($bits(s1_t)),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p0_v_q),
    .v_i     (diff),
    .side_i  (p0_q),
    .valid_o (n1_v),
    .n_o     (n1_f),
    .zero_o  (n1_z),
    .side_o  (n1_s)
  );

  // Negated forward.
  s2_t  p2_d, p2_q;
  logic p2_v_q;

  always_comb begin
    p2_d.deg = (n1_s.op == lav_pkg::OP_TARGET) && n1_z;
    p2_d.cam = n1_s.cam;
    p2_d.up  = n1_s.up;
    for (int i = 0; i < 3; i++) begin
      if (n1_s.op == lav_pkg::OP_TARGET) begin
        p2_d.nf[i] = -DW'($signed(n1_f[i]));
      end else if (n1_s.aim[i] == {1'b1, {(DW-1){1'b0}}}) begin
        p2_d.nf[i] = {1'b0, {(DW-1){1'b1}}};
      end else begin
        p2_d.nf[i] = -n1_s.aim[i];
      end
    end
  end

  // Cross product of up and negated forward: products, then halves.
  s2_t                 p3_q;
  logic [5:0][CRW-1:0] p3_d, p3p_q;
  logic                p3_v_q;

  always_comb begin
    p3_d[0] = $signed(p2_q.up[1]) * $signed(p2_q.nf[2]);
    p3_d[1] = $signed(p2_q.up[2]) * $signed(p2_q.nf[1]);
    p3_d[2] = $signed(p2_q.up[2]) * $signed(p2_q.nf[0]);
    p3_d[3] = $signed(p2_q.up[0]) * $signed(p2_q.nf[2]);
    p3_d[4] = $signed(p2_q.up[0]) * $signed(p2_q.nf[1]);
    p3_d[5] = $signed(p2_q.up[1]) * $signed(p2_q.nf[0]);
  end

  s2_t                 p4_q;
  logic [2:0][CRW-1:0] p4_d, p4c_q;
  logic                p4_v_q;
  logic signed [CRW-1:0] hb;
  logic [5:0][CRW-1:0]   half;

  // Halving rounds toward zero.
  always_comb begin
    hb = '0;
    for (int k = 0; k < 6; k++) begin
      hb      = p3p_q[k] + CRW'(p3p_q[k][CRW-1]);
      half[k] = hb >>> 1;
    end
    p4_d[0] = half[0] - half[1];
    p4_d[1] = half[2] - half[3];
    p4_d[2] = half[4] - half[5];
  end

  // Right vector.
  logic               n2_v;
  logic [2:0][NW-1:0] n2_r;
  logic               n2_z;
  s2_t                n2_s;

  lav_norm #(
    .W         (CRW),
    .P         ($bits(s2_t)),
    .FRAC_BITS (FRAC_BITS)
  ) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p4_v_q),
    .v_i     (p4c_q),
    .side_i  (p4_q),
    .valid_o (n2_v),
    .n_o     (n2_r),
    .zero_o  (n2_z),
    .side_o  (n2_s)
  );

  // Translation products row[i] * -cam[i].
  logic [2:0][2:0][DW-1:0] p5r_d, p5r_q;
  logic [2:0][2:0][PW-1:0] p5p_d, p5p_q;
  logic                    p5deg_q;
  logic                    p5_v_q;
  logic signed [DW:0]      ncam [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ncam[i]     = -$signed({n2_s.cam[i][DW-1], n2_s.cam[i]});
      p5r_d[0][i] = DW'($signed(n2_r[i]));
      p5r_d[1][i] = n2_s.up[i];
      p5r_d[2][i] = n2_s.nf[i];
    end
    for (int w = 0; w < 3; w++) begin
      for (int i = 0; i < 3; i++) begin
        p5p_d[w][i] = $signed(p5r_d[w][i]) * ncam[i];
      end
    end
  end

  // Sums.
  logic [2:0][2:0][DW-1:0] p6r_q;
  logic [2:0][SUMW-1:0]    p6s_d, p6s_q;
  logic                    p6deg_q;
  logic                    p6_v_q;

  always_comb begin
    for (int w = 0; w < 3; w++) begin
      p6s_d[w] = SUMW'($signed(p5p_q[w][0])) + SUMW'($signed(p5p_q[w][1]))
               + SUMW'($signed(p5p_q[w][2]));
    end
  end

  // Floor shift and saturation.
  tail_t tail_d, tail_q;
  logic  tail_v_q;
  logic signed [SUMW-1:0] sh;

  always_comb begin
    tail_d.rows = p6r_q;
    tail_d.deg  = p6deg_q;
    sh          = '0;
    for (int w = 0; w < 3; w++) begin
      sh = $signed(p6s_q[w]) >>> FRAC_BITS;
      if (sh > SatHi) begin
        tail_d.t[w] = SatHi[DW-1:0];
      end else if (sh < SatLo) begin
        tail_d.t[w] = SatLo[DW-1:0];
      end else begin
        tail_d.t[w] = sh[DW-1:0];
      end
    end
  end

  // Row sequencer holding one finished matrix.
  tail_t      hold_q;
  logic       hold_v_q;
  logic [1:0] cnt_q;

  assign out_acc    = hold_v_q && !out_stall_i;
  assign take       = !hold_v_q || (out_acc && (cnt_q == lav_pkg::ROW_LAST));
  assign en         = !tail_v_q || take;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q   <= 1'b0;
      p2_v_q   <= 1'b0;
      p3_v_q   <= 1'b0;
      p4_v_q   <= 1'b0;
      p5_v_q   <= 1'b0;
      p6_v_q   <= 1'b0;
      tail_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q   <= in_valid_i;
      p2_v_q   <= n1_v;
      p3_v_q   <= p2_v_q;
      p4_v_q   <= p3_v_q;
      p5_v_q   <= n2_v;
      p6_v_q   <= p5_v_q;
      tail_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q.op     <= op_i;
      p0_q.cam    <= {cam_z_i, cam_y_i, cam_x_i};
      p0_q.aim    <= {aim_z_i, aim_y_i, aim_x_i};
      p0_q.up     <= {up_z_i, up_y_i, up_x_i};
      p2_q        <= p2_d;
      p3_q        <= p2_q;
      p3p_q       <= p3_d;
      p4_q        <= p3_q;
      p4c_q       <= p4_d;
      p5r_q       <= p5r_d;
      p5p_q       <= p5p_d;
      p5deg_q     <= n2_s.deg || n2_z;
      p6r_q       <= p5r_q;
      p6s_q       <= p6s_d;
      p6deg_q     <= p5deg_q;
      tail_q      <= tail_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      cnt_q    <= lav_pkg::ROW_RIGHT;
    end else if (take) begin
      hold_v_q <= tail_v_q;
      cnt_q    <= lav_pkg::ROW_RIGHT;
    end else if (out_acc) begin
      cnt_q    <= cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_q <= tail_q;
    end
  end

  always_comb begin
    case (cnt_q)
      lav_pkg::ROW_RIGHT: begin
        col0_o = hold_q.rows[0][0];
        col1_o = hold_q.rows[0][1];
        col2_o = hold_q.rows[0][2];
        col3_o = hold_q.t[0];
      end
      lav_pkg::ROW_UP: begin
        col0_o = hold_q.rows[1][0];
        col1_o = hold_q.rows[1][1];
        col2_o = hold_q.rows[1][2];
        col3_o = hold_q.t[1];
      end
      lav_pkg::ROW_FWD: begin
        col0_o = hold_q.rows[2][0];
        col1_o = hold_q.rows[2][1];
        col2_o = hold_q.rows[2][2];
        col3_o = hold_q.t[2];
      end
      default: begin
        col0_o = '0;
        col1_o = '0;
        col2_o = '0;
        col3_o = One;
      end
    endcase
  end

  assign out_valid_o  = hold_v_q;
  assign row_index_o  = cnt_q;
  assign degenerate_o = hold_q.deg;
  assign last_row_o   = (cnt_q == lav_pkg::ROW_LAST);

endmodule

// ===== test/lav_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_checker
// Watches both channels of the view matrix block, works out the four row
// words of every accepted input word and compares each row word as it leaves.
// ----------------------------------------------------------------------------
module lav_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [31:0] cam_x_i,
  input  logic [31:0] cam_y_i,
  input  logic [31:0] cam_z_i,
  input  logic [31:0] aim_x_i,
  input  logic [31:0] aim_y_i,
  input  logic [31:0] aim_z_i,
  input  logic [31:0] up_x_i,
  input  logic [31:0] up_y_i,
  input  logic [31:0] up_z_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  row_index_i,
  input  logic [31:0] col0_i,
  input  logic [31:0] col1_i,
  input  logic [31:0] col2_i,
  input  logic [31:0] col3_i,
  input  logic        degenerate_i,
  input  logic        last_row_i,
  output int          fail_count_o,
  output int          pending_rows_o
);

  typedef struct packed {
    logic [1:0]  row;
    logic [31:0] c0, c1, c2, c3;
    logic        deg;
    logic        last;
  } row_word_t;

  typedef logic signed [63:0] s64_t;
  typedef s64_t vec3_t [3];

  row_word_t expected_rows[$];
  int        fails;

  function automatic s64_t clamp32(s64_t v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Returns 0 when the vector has zero length; n is then all zeros.
  function automatic bit unit_vec(vec3_t v, output vec3_t n);
    logic [63:0] m [3];
    logic [63:0] mx, s, len, q;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? 64'd0 - 64'(v[i]) : 64'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    n[0] = 0; n[1] = 0; n[2] = 0;
    if (mx == 0) return 0;
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
    len = root64(s);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FRAC_BITS) / len;
      n[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  // Exact sum of row * -cam, floored to the fraction and then clamped.
  function automatic s64_t translation(vec3_t row, vec3_t cam);
    s64_t d, p, q, r, qs, rs;
    d = s64_t'(1) << FRAC_BITS;
    qs = 0;
    rs = 0;
    for (int i = 0; i < 3; i++) begin
      p = row[i] * (-cam[i]);
      q = p / d;
      r = p % d;
      if (r < 0) begin
        q = q - 1;
        r = r + d;
      end
      qs = qs + q;
      rs = rs + r;
    end
    return clamp32(qs + rs / d);
  endfunction

  function automatic row_word_t make_row(logic [1:0] idx, vec3_t v, s64_t t, bit deg);
    row_word_t w;
    w.row = idx;
    w.c0 = v[0][31:0];
    w.c1 = v[1][31:0];
    w.c2 = v[2][31:0];
    w.c3 = t[31:0];
    w.deg = deg;
    w.last = (idx == lav_pkg::ROW_LAST);
    return w;
  endfunction

  task automatic predict_view_rows();
    vec3_t cam, aim, up, nf, cr, rgt, dif, fwd, zero;
    bit    deg;
    deg = 0;
    cam[0] = $signed(cam_x_i); cam[1] = $signed(cam_y_i); cam[2] = $signed(cam_z_i);
    aim[0] = $signed(aim_x_i); aim[1] = $signed(aim_y_i); aim[2] = $signed(aim_z_i);
    up[0]  = $signed(up_x_i);  up[1]  = $signed(up_y_i);  up[2]  = $signed(up_z_i);
    zero[0] = 0; zero[1] = 0; zero[2] = 0;
    if (lav_pkg::op_e'(op_i) == lav_pkg::OP_TARGET) begin
      for (int i = 0; i < 3; i++) dif[i] = aim[i] - cam[i];
      if (!unit_vec(dif, fwd)) deg = 1;
      for (int i = 0; i < 3; i++) nf[i] = -fwd[i];
    end else begin
      for (int i = 0; i < 3; i++) nf[i] = clamp32(-aim[i]);
    end
    cr[0] = (up[1] * nf[2]) / 2 - (up[2] * nf[1]) / 2;
    cr[1] = (up[2] * nf[0]) / 2 - (up[0] * nf[2]) / 2;
    cr[2] = (up[0] * nf[1]) / 2 - (up[1] * nf[0]) / 2;
    if (!unit_vec(cr, rgt)) deg = 1;
    expected_rows.push_back(make_row(lav_pkg::ROW_RIGHT, rgt, translation(rgt, cam), deg));
    expected_rows.push_back(make_row(lav_pkg::ROW_UP, up, translation(up, cam), deg));
    expected_rows.push_back(make_row(lav_pkg::ROW_FWD, nf, translation(nf, cam), deg));
    expected_rows.push_back(make_row(lav_pkg::ROW_LAST, zero, s64_t'(1) << FRAC_BITS,
                                     deg));
  endtask

  task automatic report(string what, row_word_t exp_w, row_word_t got_w);
    fails++;
    if (fails <= 10)
      $display({"mismatch %s: expected row=%0d c=%h %h %h %h deg=%b last=%b,",
                " got row=%0d c=%h %h %h %h deg=%b last=%b"},
               what, exp_w.row, exp_w.c0, exp_w.c1, exp_w.c2, exp_w.c3, exp_w.deg,
               exp_w.last, got_w.row, got_w.c0, got_w.c1, got_w.c2, got_w.c3,
               got_w.deg, got_w.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    row_word_t got_w, exp_w;
    if (!rst_ni) begin
      fails = 0;
      expected_rows.delete();
    end else begin
      if (in_valid_i && !in_stall_i) predict_view_rows();
      if (out_valid_i && !out_stall_i) begin
        got_w = '{row_index_i, col0_i, col1_i, col2_i, col3_i, degenerate_i, last_row_i};
        if (expected_rows.size() == 0) begin
          report("unexpected word", '0, got_w);
        end else begin
          exp_w = expected_rows.pop_front();
          if (got_w !== exp_w) report("row word", exp_w, got_w);
        end
      end
    end
  end

  assign fail_count_o = fails;
  assign pending_rows_o = expected_rows.size();

endmodule

// ===== test/tb_look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// Drives directed and random camera words into the view matrix block with
// random gaps and output stalls; a checker beside the block compares rows.
// ----------------------------------------------------------------------------
module tb_look_at_view_matrix;

  localparam int unsigned FRAC_BITS = 16;
  localparam int          LATENCY   = 90 + 2 * FRAC_BITS;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = 1'b0;
  logic [31:0] cam_x = '0, cam_y = '0, cam_z = '0;
  logic [31:0] aim_x = '0, aim_y = '0, aim_z = '0;
  logic [31:0] up_x = '0, up_y = '0, up_z = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  row_index;
  logic [31:0] col0, col1, col2, col3;
  logic        degenerate, last_row;
  int          fail_count, pending_rows;
  int          stall_left = 0;
  bit          sending_done = 0;

  always #6 clk_i = ~clk_i;

  look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .op_i(op),
    .cam_x_i(cam_x), .cam_y_i(cam_y), .cam_z_i(cam_z),
    .aim_x_i(aim_x), .aim_y_i(aim_y), .aim_z_i(aim_z),
    .up_x_i(up_x), .up_y_i(up_y), .up_z_i(up_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .row_index_o(row_index), .col0_o(col0), .col1_o(col1), .col2_o(col2),
    .col3_o(col3), .degenerate_o(degenerate), .last_row_o(last_row)
  );

  lav_checker #(.FRAC_BITS(FRAC_BITS)) checker_i (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .op_i(op),
    .cam_x_i(cam_x), .cam_y_i(cam_y), .cam_z_i(cam_z),
    .aim_x_i(aim_x), .aim_y_i(aim_y), .aim_z_i(aim_z),
    .up_x_i(up_x), .up_y_i(up_y), .up_z_i(up_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .row_index_i(row_index), .col0_i(col0), .col1_i(col1), .col2_i(col2),
    .col3_i(col3), .degenerate_i(degenerate), .last_row_i(last_row),
    .fail_count_o(fail_count), .pending_rows_o(pending_rows)
  );

  // Mostly short gaps, now and then a long one, and stretches with none.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
      4: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return $urandom;
    endcase
  endfunction

  // Valid stays high across back-to-back words and drops only for a gap.
  task automatic send_word(lav_pkg::op_e o, logic [31:0] cx, cy, cz, ax, ay, az,
                           ux, uy, uz);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op <= o;
    cam_x <= cx; cam_y <= cy; cam_z <= cz;
    aim_x <= ax; aim_y <= ay; aim_z <= az;
    up_x <= ux; up_y <= uy; up_z <= uz;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_random();
    logic [31:0] cx, cy, cz, ax, ay, az;
    cx = rand_word(); cy = rand_word(); cz = rand_word();
    ax = rand_word(); ay = rand_word(); az = rand_word();
    // Now and then the aim equals the camera, a zero-length look-at in target mode.
    if ($urandom_range(0, 19) == 0) begin
      ax = cx; ay = cy; az = cz;
    end
    send_word(lav_pkg::op_e'($urandom_range(0, 1)), cx, cy, cz, ax, ay, az,
              rand_word(), rand_word(), rand_word());
  endtask

  // Output stalls come in bursts whose lengths follow the input gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 1) begin
      stall_left = stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_stall <= (stall_left != 0);
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Unit up along y in both modes: forward mode aiming along +z, then a target at the origin.
    send_word(lav_pkg::OP_FORWARD, 0, 0, 32'h0005_0000, 0, 0, 32'h0001_0000,
              0, 32'h0001_0000, 0);
    send_word(lav_pkg::OP_TARGET, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0, 0,
              0, 32'h0001_0000, 0);
    // Target equal to camera: zero-length forward.
    send_word(lav_pkg::OP_TARGET, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
              32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000, 0);
    // Up parallel to forward: zero-length right.
    send_word(lav_pkg::OP_FORWARD, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000, 0);
    // All zero.
    send_word(lav_pkg::OP_FORWARD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Most negative aim in forward mode negates with saturation.
    send_word(lav_pkg::OP_FORWARD, 32'h0000_1000, 0, 0, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h0001_0000, 0, 0);
    // Field extremes that push the translation into saturation.
    send_word(lav_pkg::OP_FORWARD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000);
    send_word(lav_pkg::OP_FORWARD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff);
    send_word(lav_pkg::OP_TARGET, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000);
    send_word(lav_pkg::OP_TARGET, 32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff,
              32'h0000_0001, 32'hffff_ffff, 32'h0000_0002, 32'hffff_ffff,
              32'h0000_0001, 32'hffff_ffff);
    send_word(lav_pkg::OP_FORWARD, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff);
    for (int k = 0; k < 100; k++) send_random();
    in_valid <= 1'b0;
    sending_done = 1;
    // Let the checker record the last accepted word before draining.
    @(posedge clk_i);
    while (pending_rows != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (fail_count == 0) $display("[look_at_view_matrix] OK");
    else $display("[look_at_view_matrix] ERROR");
    $finish;
  end

  initial begin
    #(12 * 200_000);
    $display("[look_at_view_matrix] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lav_pkg.sv
hw/rtl/lav_norm.sv
hw/rtl/look_at_view_matrix.sv
test/lav_checker.sv
test/tb_look_at_view_matrix.sv
